// ----- rtl/core/egcd_pkg.sv -----
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared constants and types for the extended GCD block.
// ----------------------------------------------------------------------------
package egcd_pkg;

  // Default operand width
  localparam int OPERAND_BITS_DEF = 31;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_DIV,
    ST_UPD
  } state_t;

  // Control from the sequencer to the divider row
  typedef struct packed {
    logic load;
    logic step;
  } ctl_t;

endpackage

// ----- rtl/core/egcd_cell.sv -----
// ----------------------------------------------------------------------------
// egcd_cell
// One bit slice of the restoring divider: holds one remainder bit and one
// dividend/quotient bit, and passes both to its upper neighbor each step.
// ----------------------------------------------------------------------------
module egcd_cell (
  input  logic            clk,
  input  egcd_pkg::ctl_t  ctl,
  input  logic            num_load,
  input  logic            rem_in,
  input  logic            num_in,
  input  logic            dvs,
  input  logic            bin,
  input  logic            qbit,
  output logic            rem,
  output logic            num,
  output logic            bout
);

  logic diff;

  // Subtract the divisor bit with borrow ripple
  assign diff = rem_in ^ dvs ^ bin;
  assign bout = (~rem_in & (dvs | bin)) | (dvs & bin);

  // Load a new dividend or shift one position per step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= 1'b0;
      num <= num_load;
    end else if (ctl.step) begin
      rem <= qbit ? diff : rem_in;
      num <= num_in;
    end
  end

endmodule

// ----- rtl/core/egcd_divrow.sv -----
// ----------------------------------------------------------------------------
// egcd_divrow
// Row of bit-slice cells forming a radix-2 restoring divider. One quotient
// bit per step, most significant first; it shifts into the dividend row.
// ----------------------------------------------------------------------------
module egcd_divrow #(
  parameter int W = egcd_pkg::OPERAND_BITS_DEF
) (
  input  logic            clk,
  input  egcd_pkg::ctl_t  ctl,
  input  logic [W-1:0]    dividend,
  input  logic [W-1:0]    divisor,
  output logic [W-1:0]    remainder,
  output logic            qbit
);

  logic [W-1:0] rem;
  logic [W-1:0] num;
  logic [W-1:0] bout;
  logic [W-1:0] rem_in;
  logic [W-1:0] num_in;
  logic [W-1:0] bin;

  // Shifted partial remainder fits once its top bit or no final borrow
  assign qbit = rem[W-1] | ~bout[W-1];

  // Chain the cells
  assign rem_in[0] = num[W-1];
  assign num_in[0] = qbit;
  assign bin[0]    = 1'b0;

  genvar i;
  generate
    for (i = 1; i < W; i++) begin : g_link
      assign rem_in[i] = rem[i-1];
      assign num_in[i] = num[i-1];
      assign bin[i]    = bout[i-1];
    end
    for (i = 0; i < W; i++) begin : g_cell
      egcd_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .num_load (dividend[i]),
        .rem_in   (rem_in[i]),
        .num_in   (num_in[i]),
        .dvs      (divisor[i]),
        .bin      (bin[i]),
        .qbit     (qbit),
        .rem      (rem[i]),
        .num      (num[i]),
        .bout     (bout[i])
      );
    end
  endgenerate

  assign remainder = rem;

endmodule

// ----- rtl/core/extended_gcd.sv -----
// ----------------------------------------------------------------------------
// extended_gcd
// Extended Euclidean algorithm: gcd of a and b with Bezout coefficients.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each Euclid step runs
// a check state that loads the bit-slice divider row, then divide states (one
// quotient bit each), then an update state; the item ends in a check state
// that finds the current remainder zero. The result is shown for one cycle
// with done high and cannot be held off; the next item may start on the edge
// that ends the done cycle.
module extended_gcd #(
  parameter int OPERAND_BITS = egcd_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPERAND_BITS-1:0] first_operand,
  input  logic [OPERAND_BITS-1:0] second_operand,
  output logic                    done,
  output logic [OPERAND_BITS-1:0] divisor,
  output logic signed [OPERAND_BITS:0] coeff_first,
  output logic signed [OPERAND_BITS:0] coeff_second
);

  localparam int W  = OPERAND_BITS;
  localparam int CW = $clog2(W);

  egcd_pkg::state_t state, state_next;
  egcd_pkg::ctl_t   ctl;

  logic [W-1:0]  r_old, r_cur;
  logic [W:0]    s_old, s_cur, t_old, t_cur;
  logic [W:0]    ps, pt;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic          qbit;
  logic          take, finish, last;

  assign take   = start & (state == egcd_pkg::ST_IDLE);
  assign finish = (state == egcd_pkg::ST_CHK) & (r_cur == '0);
  assign last   = (cnt == CW'(W - 1));

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= egcd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Next state and control
  always_comb begin
    state_next = state;
    ctl.load   = 1'b0;
    ctl.step   = 1'b0;
    busy       = 1'b1;
    case (state)
      egcd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) state_next = egcd_pkg::ST_CHK;
      end
      egcd_pkg::ST_CHK: begin
        if (r_cur == '0) begin
          state_next = egcd_pkg::ST_IDLE;
        end else begin
          ctl.load   = 1'b1;
          state_next = egcd_pkg::ST_DIV;
        end
      end
      egcd_pkg::ST_DIV: begin
        ctl.step = 1'b1;
        if (last) state_next = egcd_pkg::ST_UPD;
      end
      egcd_pkg::ST_UPD: state_next = egcd_pkg::ST_CHK;
      default: state_next = egcd_pkg::ST_IDLE;
    endcase
  end

  egcd_divrow #(.W(W)) u_row (
    .clk       (clk),
    .ctl       (ctl),
    .dividend  (r_old),
    .divisor   (r_cur),
    .remainder (rem),
    .qbit      (qbit)
  );

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= finish;
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (finish) begin
      divisor      <= r_old;
      coeff_first  <= s_old;
      coeff_second <= t_old;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst)           cnt <= '0;
    else if (ctl.load) cnt <= '0;
    else if (ctl.step) cnt <= cnt + CW'(1);
  end

  // Remainders and coefficients: load, accumulate q*s and q*t, update
  always_ff @(posedge clk) begin
    if (take) begin
      r_old <= first_operand;
      r_cur <= second_operand;
      s_old <= (W+1)'(1);
      s_cur <= '0;
      t_old <= '0;
      t_cur <= (W+1)'(1);
    end else if (ctl.load) begin
      ps <= '0;
      pt <= '0;
    end else if (ctl.step) begin
      ps <= {ps[W-1:0], 1'b0} + (qbit ? s_cur : '0);
      pt <= {pt[W-1:0], 1'b0} + (qbit ? t_cur : '0);
    end else if (state == egcd_pkg::ST_UPD) begin
      r_old <= r_cur;
      r_cur <= rem;
      s_old <= s_cur;
      s_cur <= s_old - ps;
      t_old <= t_cur;
      t_cur <= t_old - pt;
    end
  end

endmodule

// ----- verif/tb_extended_gcd.sv -----
// ----------------------------------------------------------------------------
// tb_extended_gcd
// Self-checking bench for the extended GCD block: directed corner operands,
// then random pairs with random start gaps, each result checked against an
// in-bench Euclid predictor.
// ----------------------------------------------------------------------------
module tb_extended_gcd;

  localparam int W = egcd_pkg::OPERAND_BITS_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [W-1:0] gcd_val;
    logic [W:0]   s_val;
    logic [W:0]   t_val;
  } bezout_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic [W-1:0] first_operand = '0;
  logic [W-1:0] second_operand = '0;
  logic         busy, done;
  logic [W-1:0] divisor;
  logic signed [W:0] coeff_first, coeff_second;

  bezout_t bezout_q[$];
  int      mismatches = 0;
  int      beats_sent = 0;
  int      beats_checked = 0;
  int      cycles = 0;

  extended_gcd uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_operand(first_operand), .second_operand(second_operand),
    .done(done), .divisor(divisor),
    .coeff_first(coeff_first), .coeff_second(coeff_second)
  );

  always #6 clk = ~clk;

  // Compute gcd and Bezout pair with wrapping 64-bit coefficient arithmetic
  function automatic bezout_t euclid_bezout(logic [W-1:0] a, logic [W-1:0] b);
    logic [63:0] r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
    bezout_t res;
    r0 = 64'(a); r1 = 64'(b); s0 = 64'd1; s1 = 64'd0; t0 = 64'd0; t1 = 64'd1;
    while (r1 != 0) begin
      q = r0 / r1;
      rn = r0 - q * r1;
      sn = s0 - q * s1;
      tn = t0 - q * t1;
      r0 = r1; r1 = rn; s0 = s1; s1 = sn; t0 = t1; t1 = tn;
    end
    res.gcd_val = r0[W-1:0];
    res.s_val = s0[W:0];
    res.t_val = t0[W:0];
    return res;
  endfunction

  // Count cycles; stop the run on timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    bezout_t exp_r;
    if (!rst && done) begin
      if (bezout_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat at cycle %0d", cycles);
      end else begin
        exp_r = bezout_q.pop_front();
        beats_checked++;
        if (divisor !== exp_r.gcd_val || coeff_first !== exp_r.s_val ||
            coeff_second !== exp_r.t_val) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp g=%0d s=%0d t=%0d got g=%0d s=%0d t=%0d",
                     exp_r.gcd_val, $signed(exp_r.s_val), $signed(exp_r.t_val),
                     divisor, coeff_first, coeff_second);
        end
      end
    end
  end

  // Send one operand pair after a gap, hold start until accepted
  task automatic send_pair(logic [W-1:0] a, logic [W-1:0] b, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    first_operand <= a;
    second_operand <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    bezout_q.push_back(euclid_bezout(a, b));
    beats_sent++;
  endtask

  task automatic test_corners();
    logic [W-1:0] mx;
    mx = {W{1'b1}};
    send_pair(W'(0), W'(0), 0);
    send_pair(mx, W'(0), 0);
    send_pair(W'(0), mx, 1);
    send_pair(W'(0), W'(1), 0);
    send_pair(W'(1), W'(0), 0);
    send_pair(W'(1), W'(1), 2);
    send_pair(mx, mx, 0);
    send_pair(mx, W'(1), 0);
    send_pair(W'(1), mx, 0);
    send_pair(mx, mx - W'(1), 3);
    send_pair(mx - W'(1), mx, 0);
    send_pair(W'(1836311903), W'(1134903170), 0); // consecutive Fibonacci: most steps
    send_pair(W'(1134903170), W'(1836311903), 0);
    send_pair(W'(12), W'(18), 0);
    send_pair(W'(18), W'(12), 0);
    send_pair(W'(1) << (W - 1), W'(1) << (W - 2), 0);
    send_pair(W'(7), W'(7), 0);
    send_pair(W'(2147483629), W'(2147483587), 0);
  endtask

  task automatic test_random_pairs(int n);
    logic [W-1:0] a, b, k;
    int gap;
    for (int i = 0; i < n; i++) begin
      a = W'($urandom);
      b = W'($urandom);
      case ($urandom_range(0, 7))
        0: a = W'($urandom_range(0, 40));
        1: b = W'($urandom_range(0, 40));
        2: begin
          // shared factor gives a large gcd
          k = W'($urandom_range(1, 1000));
          a = W'($urandom_range(0, 2000000)) * k;
          b = W'($urandom_range(0, 2000000)) * k;
        end
        3: b = a;
        default: ;
      endcase
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      send_pair(a, b, gap);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_random_pairs(400);
    start <= 1'b0;
    while (bezout_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d operand pairs (corners and random), checked %0d results",
             beats_sent, beats_checked);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- extended_gcd.f -----
rtl/core/egcd_pkg.sv
rtl/core/egcd_cell.sv
rtl/core/egcd_divrow.sv
rtl/core/extended_gcd.sv
verif/tb_extended_gcd.sv
